[rtl/rle_pkg.sv]
package rle_pkg;

	// fixed field widths
	localparam int ROW_W  = 8;
	localparam int COL_W  = 8;
	localparam int OFS_W  = 10;
	localparam int PITCH_W = 11;
	localparam int ADDR_W = 20;
	localparam int CFG_W  = 11;

	// row bitmap of a delta frame
	localparam int BITMAP_BYTES = 15;
	localparam int BITMAP_ROWS  = BITMAP_BYTES * 8;
	localparam int BCNT_W       = 4;

	// frame type byte codes
	localparam logic [7:0] TYPE_KEY   = 8'h00;
	localparam logic [7:0] TYPE_DELTA = 8'h01;
	localparam logic [7:0] TYPE_DUP   = 8'h02;

	// run byte layout
	localparam logic [7:0] RUN_MASK   = 8'h7F;
	localparam logic [7:0] ROW_END    = 8'h00;

	// configuration register indexes
	localparam logic [1:0] CFG_X_OFFSET   = 2'd0;
	localparam logic [1:0] CFG_Y_OFFSET   = 2'd1;
	localparam logic [1:0] CFG_LINE_PITCH = 2'd2;

	// reset values of the registers
	localparam logic [OFS_W-1:0]   X_OFFSET_RST   = 10'd40;
	localparam logic [OFS_W-1:0]   Y_OFFSET_RST   = 10'd40;
	localparam logic [PITCH_W-1:0] LINE_PITCH_RST = 11'd240;

	typedef enum logic [1:0] {
		KIND_SPAN    = 2'd0,
		KIND_COPY    = 2'd1,
		KIND_END     = 2'd2,
		KIND_UNKNOWN = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [6:0]         row;
		logic [7:0]         column;
		logic [6:0]         span_length;
		logic               color;
		logic [ADDR_W-1:0]  pixel_address;
		logic               last;
	} out_item_t;

endpackage

[rtl/rle_bilevel_frame_decoder_unit.sv]
// Run-length bi-level frame decoder. Takes one compressed byte per item and
// gives at most one result per item: a span fill with its framebuffer
// address, a copy-previous-frame command, an end-of-frame marker or an
// unknown-type notice. An item is taken every cycle without in_stall; its
// result is in the output register next cycle. in_stall is high only while
// that register holds a result that the far side stalls. The per-item path
// is the row search over the delta bitmap and one 11x11 multiply-add for the
// address, both between the state registers and the output register.
module rle_bilevel_frame_decoder_unit #(
	parameter int VIDEO_COLUMNS = 160,
	parameter int VIDEO_ROWS    = 120
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rle_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output rle_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [rle_pkg::CFG_W-1:0] cfg_data
);
	import rle_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_KEY,
		PH_BITMAP,
		PH_DELTA
	} phase_t;

	localparam logic [COL_W-1:0] COLS = COL_W'(VIDEO_COLUMNS);
	localparam logic [ROW_W-1:0] ROWS = ROW_W'(VIDEO_ROWS);

	phase_t                phase_q, nxt_phase;
	logic [ROW_W-1:0]      row_q, nxt_row;
	logic [COL_W-1:0]      col_q, nxt_col;
	logic [BCNT_W-1:0]     bcnt_q, nxt_bcnt;
	logic [7:0]            bitmap_q [BITMAP_BYTES];
	logic                  bm_we;
	logic [OFS_W-1:0]      x_off_q, y_off_q;
	logic [PITCH_W-1:0]    pitch_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  acc;
	logic                  res_v;
	out_item_t             res;

	// row search
	logic [BITMAP_ROWS-1:0] flags, cand;
	logic [BITMAP_BYTES-1:0] byte_any;
	logic [ROW_W-1:0]      from;
	logic [BCNT_W-1:0]     hit_byte;
	logic [7:0]            hit_bits;
	logic [2:0]            hit_bit;
	logic                  found;
	logic [ROW_W-1:0]      next_row;

	// span
	logic [6:0]            run;
	logic [COL_W-1:0]      room;
	logic [6:0]            len;
	logic [PITCH_W-1:0]    row_sum;
	logic [2*PITCH_W-1:0]  prod;
	logic [ADDR_W-1:0]     addr;

	assign in_stall  = out_valid_q && out_stall;
	assign acc       = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// row flags, last bitmap byte taken straight from the input
	always_comb begin
		for (int j = 0; j < BITMAP_BYTES; j++) begin
			for (int k = 0; k < 8; k++) begin
				if (phase_q == PH_BITMAP && j == BITMAP_BYTES - 1)
					flags[8*j+k] = in_data.data_byte[7-k];
				else
					flags[8*j+k] = bitmap_q[j][7-k];
			end
		end
	end

	assign from = (phase_q == PH_BITMAP) ? '0 : row_q + ROW_W'(1);

	// flagged rows at or after the start row and inside the video
	always_comb begin
		for (int i = 0; i < BITMAP_ROWS; i++)
			cand[i] = flags[i] && (ROW_W'(i) >= from) && (i < VIDEO_ROWS);
		for (int j = 0; j < BITMAP_BYTES; j++)
			byte_any[j] = |cand[8*j +: 8];
	end

	// first byte with a candidate, then first bit inside it
	always_comb begin
		hit_byte = '0;
		for (int j = BITMAP_BYTES - 1; j >= 0; j--)
			if (byte_any[j])
				hit_byte = BCNT_W'(j);
		hit_bits = cand[8*hit_byte +: 8];
		hit_bit = '0;
		for (int k = 7; k >= 0; k--)
			if (hit_bits[k])
				hit_bit = 3'(k);
	end

	// next decoded row: plain increment for keyframes, bitmap search for deltas
	always_comb begin
		if (phase_q == PH_KEY) begin
			found    = from < ROWS;
			next_row = from;
		end else begin
			found    = |byte_any;
			next_row = ROW_W'({hit_byte, hit_bit});
		end
	end

	// run clipping and span address
	assign run     = in_data.data_byte[6:0] & RUN_MASK[6:0];
	assign room    = (col_q < COLS) ? COLS - col_q : '0;
	assign len     = (COL_W'(run) < room) ? run : 7'(room);
	assign row_sum = PITCH_W'(row_q) + PITCH_W'(y_off_q);
	assign prod    = (2*PITCH_W)'(row_sum) * (2*PITCH_W)'(pitch_q);
	assign addr    = prod[ADDR_W-1:0] + ADDR_W'(col_q) + ADDR_W'(x_off_q);

	// next state and result of one item
	always_comb begin
		nxt_phase = phase_q;
		nxt_row   = row_q;
		nxt_col   = col_q;
		nxt_bcnt  = bcnt_q;
		bm_we     = 1'b0;
		res_v     = 1'b0;
		res       = '0;
		if (in_data.frame_start) begin
			nxt_row  = '0;
			nxt_col  = '0;
			nxt_bcnt = '0;
			res_v    = 1'b1;
			res.last = 1'b1;
			nxt_phase = PH_IDLE;
			case (in_data.data_byte)
				TYPE_KEY: begin
					nxt_phase = PH_KEY;
					res_v     = 1'b0;
					res.last  = 1'b0;
				end
				TYPE_DELTA: begin
					nxt_phase = PH_BITMAP;
					res.kind  = KIND_COPY;
					res.last  = 1'b0;
				end
				TYPE_DUP: begin
					res.kind = KIND_COPY;
				end
				default: begin
					res.kind = KIND_UNKNOWN;
				end
			endcase
		end else begin
			case (phase_q)
				PH_BITMAP: begin
					bm_we = 1'b1;
					if (bcnt_q == BCNT_W'(BITMAP_BYTES - 1)) begin
						nxt_bcnt = '0;
						nxt_col  = '0;
						if (found) begin
							nxt_row   = next_row;
							nxt_phase = PH_DELTA;
						end else begin
							nxt_row   = '0;
							nxt_phase = PH_IDLE;
							res_v     = 1'b1;
							res.kind  = KIND_END;
							res.last  = 1'b1;
						end
					end else begin
						nxt_bcnt = bcnt_q + BCNT_W'(1);
					end
				end
				PH_KEY, PH_DELTA: begin
					if (in_data.data_byte == ROW_END) begin
						nxt_col = '0;
						if (found) begin
							nxt_row = next_row;
						end else begin
							nxt_row   = '0;
							nxt_phase = PH_IDLE;
							res_v     = 1'b1;
							res.kind  = KIND_END;
							res.last  = 1'b1;
						end
					end else if (len != '0) begin
						res_v             = 1'b1;
						res.kind          = KIND_SPAN;
						res.row           = row_q[6:0];
						res.column        = col_q;
						res.span_length   = len;
						res.color         = in_data.data_byte[7];
						res.pixel_address = addr;
						nxt_col           = col_q + COL_W'(len);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// state, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			bcnt_q      <= '0;
			x_off_q     <= X_OFFSET_RST;
			y_off_q     <= Y_OFFSET_RST;
			pitch_q     <= LINE_PITCH_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_X_OFFSET:   x_off_q <= cfg_data[OFS_W-1:0];
					CFG_Y_OFFSET:   y_off_q <= cfg_data[OFS_W-1:0];
					CFG_LINE_PITCH: pitch_q <= cfg_data[PITCH_W-1:0];
					default: begin
					end
				endcase
			end
			if (acc) begin
				phase_q <= nxt_phase;
				row_q   <= nxt_row;
				col_q   <= nxt_col;
				bcnt_q  <= nxt_bcnt;
			end
			if (acc && res_v)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// bitmap bytes and result payload
	always_ff @(posedge clk) begin
		if (acc && bm_we)
			bitmap_q[bcnt_q] <= in_data.data_byte;
		if (acc && res_v)
			out_q <= res;
	end

	// bitmap count stays inside the bitmap
	a_bcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q <= BCNT_W'(BITMAP_BYTES - 1))
		else $error("bitmap byte count out of range");

	// column never passes the row width
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COLS)
		else $error("column counter past row width");

	// a decoding phase always points at a row inside the video
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_KEY || phase_q == PH_DELTA) |-> row_q < ROWS)
		else $error("row counter outside video while decoding");

	// a delta type byte moves to bitmap collection with a cleared count
	a_delta_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_data.frame_start && in_data.data_byte == TYPE_DELTA
		|=> phase_q == PH_BITMAP && bcnt_q == '0 && out_valid_q)
		else $error("delta frame start not followed by bitmap phase");

endmodule

[tb/sv/rle_bilevel_frame_decoder_unit_test.sv]
module rle_bilevel_frame_decoder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rle_pkg::*;

	localparam int VIDEO_COLUMNS = 160;
	localparam int VIDEO_ROWS    = 120;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int LONG_HOLD     = 200;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_WAIT      = 16;

	// register index past the end of the register list
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		DEC_IDLE,
		DEC_KEY,
		DEC_BITMAP,
		DEC_DELTA
	} dec_phase_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_stall;
	out_item_t        out_data;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	rle_bilevel_frame_decoder_unit #(
		.VIDEO_COLUMNS(VIDEO_COLUMNS),
		.VIDEO_ROWS(VIDEO_ROWS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// compressed stream waiting to be sent, decoded commands waiting to come out
	in_item_t  stream_q[$];
	out_item_t decoded_q[$];

	int pushed;
	int mismatches;
	int cycles;
	int idle_level;
	int hold_requests;
	int holds_done;
	int hold_left;
	int in_gap;
	int out_wait;
	bit in_accepted;
	bit out_accepted;

	// decoder state mirrored by the testbench
	logic [OFS_W-1:0]   x_off;
	logic [OFS_W-1:0]   y_off;
	logic [PITCH_W-1:0] pitch;
	dec_phase_t         dec_phase;
	int unsigned        dec_row;
	int unsigned        dec_col;
	int unsigned        bitmap_count;
	logic [7:0]         row_flags [BITMAP_BYTES];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int draw_wait();
		case (idle_level)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
			default: return $urandom_range(0, MAX_WAIT);
		endcase
	endfunction

	function automatic bit row_flagged(int unsigned r);
		if (r >= BITMAP_ROWS)
			return 1'b0;
		return row_flags[r >> 3][7 - (r & 7)];
	endfunction

	// first row at or after r that the current frame decodes
	function automatic int unsigned first_decoded_row(int unsigned r, bit delta);
		while (r < VIDEO_ROWS) begin
			if (!delta || row_flagged(r))
				return r;
			r++;
		end
		return VIDEO_ROWS;
	endfunction

	// one compressed byte in, at most one command out
	function automatic bit decode_byte(input in_item_t it, output out_item_t res);
		logic [7:0]  b;
		int unsigned run_len;
		int unsigned room;
		int unsigned len;
		logic [31:0] addr;
		b = it.data_byte;
		res = '0;
		if (it.frame_start) begin
			dec_row = 0;
			dec_col = 0;
			bitmap_count = 0;
			if (b == TYPE_KEY) begin
				dec_phase = DEC_KEY;
				return 1'b0;
			end
			if (b == TYPE_DELTA) begin
				dec_phase = DEC_BITMAP;
				res.kind = KIND_COPY;
				return 1'b1;
			end
			dec_phase = DEC_IDLE;
			if (b == TYPE_DUP)
				res.kind = KIND_COPY;
			else
				res.kind = KIND_UNKNOWN;
			res.last = 1'b1;
			return 1'b1;
		end
		if (dec_phase == DEC_BITMAP) begin
			row_flags[bitmap_count] = b;
			bitmap_count++;
			if (bitmap_count < BITMAP_BYTES)
				return 1'b0;
			bitmap_count = 0;
			dec_row = first_decoded_row(0, 1'b1);
			dec_col = 0;
			if (dec_row >= VIDEO_ROWS) begin
				// delta with no flagged row ends right after the bitmap
				dec_phase = DEC_IDLE;
				dec_row = 0;
				res.kind = KIND_END;
				res.last = 1'b1;
				return 1'b1;
			end
			dec_phase = DEC_DELTA;
			return 1'b0;
		end
		if (dec_phase == DEC_IDLE)
			return 1'b0;
		// end of row
		if (b == ROW_END) begin
			dec_row = first_decoded_row(dec_row + 1, dec_phase == DEC_DELTA);
			dec_col = 0;
			if (dec_row >= VIDEO_ROWS) begin
				dec_phase = DEC_IDLE;
				dec_row = 0;
				res.kind = KIND_END;
				res.last = 1'b1;
				return 1'b1;
			end
			return 1'b0;
		end
		// run, clipped at the row width
		run_len = 32'(b & RUN_MASK);
		room = (dec_col < VIDEO_COLUMNS) ? VIDEO_COLUMNS - dec_col : 0;
		len = (run_len < room) ? run_len : room;
		if (len == 0)
			return 1'b0;
		addr = (dec_row + y_off) * pitch + dec_col + x_off;
		res.kind = KIND_SPAN;
		res.row = dec_row[6:0];
		res.column = dec_col[7:0];
		res.span_length = len[6:0];
		res.color = b[7];
		res.pixel_address = addr[ADDR_W-1:0];
		dec_col += len;
		return 1'b1;
	endfunction

	function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// sender: next item only once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_accepted) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (stream_q.size() != 0) begin
				in_data <= stream_q.pop_front();
				in_valid <= 1'b1;
				in_gap = draw_wait();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold on request
	always @(negedge clk) begin
		if (out_accepted)
			out_wait = draw_wait();
		if (holds_done != hold_requests) begin
			hold_left = LONG_HOLD;
			holds_done = hold_requests;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (out_wait > 0) begin
			out_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watch both handshakes, predict and compare
	always @(posedge clk) begin : watch
		out_item_t want;
		out_item_t res;
		if (!arst_n) begin
			in_accepted = 1'b0;
			out_accepted = 1'b0;
		end else begin
			out_accepted = out_valid && !out_stall;
			if (out_accepted) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual 0x%0h",
						$time, out_data);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					check_field("kind", 32'(out_data.kind), 32'(want.kind));
					check_field("row", 32'(out_data.row), 32'(want.row));
					check_field("column", 32'(out_data.column), 32'(want.column));
					check_field("span_length", 32'(out_data.span_length),
						32'(want.span_length));
					check_field("color", 32'(out_data.color), 32'(want.color));
					check_field("pixel_address", 32'(out_data.pixel_address),
						32'(want.pixel_address));
					check_field("last", 32'(out_data.last), 32'(want.last));
				end
			end
			in_accepted = in_valid && !in_stall;
			if (in_accepted) begin
				if (decode_byte(in_data, res))
					decoded_q.push_back(res);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void push_byte(logic [7:0] b, logic start);
		in_item_t it;
		it.data_byte = b;
		it.frame_start = start;
		stream_q.push_back(it);
		pushed++;
	endfunction

	// a few runs of mixed lengths, then the row end
	function automatic void push_row(int runs);
		int pick;
		logic [6:0] len;
		for (int i = 0; i < runs; i++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				len = 7'd0;
			else if (pick < 4)
				len = 7'($urandom_range(1, 8));
			else
				len = 7'($urandom_range(1, 127));
			push_byte({1'($urandom_range(0, 1)), len}, 1'b0);
		end
		push_byte(ROW_END, 1'b0);
	endfunction

	function automatic void push_key_frame(int rows, bit sparse);
		int runs;
		push_byte(TYPE_KEY, 1'b1);
		for (int r = 0; r < rows; r++) begin
			if (sparse)
				runs = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
			else
				runs = $urandom_range(0, 4);
			push_row(runs);
		end
	endfunction

	function automatic void push_delta_frame();
		logic [7:0] bits [BITMAP_BYTES];
		int n_rows;
		int r;
		foreach (bits[i])
			bits[i] = 8'h00;
		n_rows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
		for (int i = 0; i < n_rows; i++) begin
			if ($urandom_range(0, 3) == 0)
				r = $urandom_range(0, 1) ? 0 : VIDEO_ROWS - 1;
			else
				r = $urandom_range(0, VIDEO_ROWS - 1);
			bits[r >> 3][7 - (r & 7)] = 1'b1;
		end
		// now and then a dense bitmap byte
		if ($urandom_range(0, 7) == 0)
			bits[$urandom_range(0, BITMAP_BYTES - 1)] = 8'($urandom_range(0, 255));
		push_byte(TYPE_DELTA, 1'b1);
		foreach (bits[i])
			push_byte(bits[i], 1'b0);
		for (int row = 0; row < VIDEO_ROWS; row++) begin
			if (bits[row >> 3][7 - (row & 7)])
				push_row($urandom_range(0, 3));
		end
	endfunction

	// mostly well-formed frames, some aborted frames and stray bytes
	task automatic gen_random(int budget);
		int stop_at;
		int pick;
		stop_at = pushed + budget;
		while (pushed < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				push_delta_frame();
			end else if (pick < 60) begin
				push_key_frame($urandom_range(1, 4), 1'b0);
			end else if (pick < 70) begin
				push_byte(TYPE_DUP, 1'b1);
			end else if (pick < 78) begin
				push_byte(8'($urandom_range(3, 255)), 1'b1);
				repeat ($urandom_range(0, 3))
					push_byte(8'($urandom_range(0, 255)), 1'b0);
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 3))
					push_byte(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				// delta cut off inside its bitmap
				push_byte(TYPE_DELTA, 1'b1);
				repeat ($urandom_range(0, BITMAP_BYTES - 1))
					push_byte(8'($urandom_range(0, 255)), 1'b0);
			end
		end
	endtask

	// wait until everything sent has been decoded and checked
	task automatic settle();
		do
			@(posedge clk);
		while (stream_q.size() != 0 || in_valid || decoded_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_X_OFFSET: x_off = value[OFS_W-1:0];
			CFG_Y_OFFSET: y_off = value[OFS_W-1:0];
			CFG_LINE_PITCH: pitch = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pushed = 0;
		mismatches = 0;
		cycles = 0;
		idle_level = 0;
		hold_requests = 0;
		holds_done = 0;
		hold_left = 0;
		in_gap = 0;
		out_wait = 0;
		in_accepted = 1'b0;
		out_accepted = 1'b0;
		x_off = X_OFFSET_RST;
		y_off = Y_OFFSET_RST;
		pitch = LINE_PITCH_RST;
		dec_phase = DEC_IDLE;
		dec_row = 0;
		dec_col = 0;
		bitmap_count = 0;
		foreach (row_flags[i])
			row_flags[i] = 8'h00;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// stray byte while idle, duplicate, unknown type and what follows it
		push_byte(8'h55, 1'b0);
		push_byte(TYPE_DUP, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h11, 1'b0);
		// longest runs of both colors, clipping, full row, zero length
		push_byte(TYPE_KEY, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h81, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(ROW_END, 1'b0);
		push_byte(8'h01, 1'b0);
		// new frame aborts the keyframe; delta with nothing flagged
		push_byte(TYPE_DELTA, 1'b1);
		repeat (BITMAP_BYTES) push_byte(8'h00, 1'b0);

		push_key_frame(VIDEO_ROWS, 1'b1);
		gen_random(110);
		settle();

		for (int ph = 1; ph < 6; ph++) begin
			case (ph)
				1: begin
					write_reg(CFG_X_OFFSET, 11'd0);
					write_reg(CFG_Y_OFFSET, 11'd0);
					write_reg(CFG_LINE_PITCH, 11'd1);
				end
				2: begin
					write_reg(CFG_X_OFFSET, 11'd1023);
					write_reg(CFG_Y_OFFSET, 11'd1023);
					write_reg(CFG_LINE_PITCH, 11'd1024);
				end
				3: begin
					write_reg(CFG_X_OFFSET, 11'($urandom_range(0, 2047)));
					write_reg(CFG_Y_OFFSET, 11'($urandom_range(0, 2047)));
					write_reg(CFG_LINE_PITCH, 11'd0);
					write_reg(CFG_UNUSED, 11'($urandom_range(0, 2047)));
				end
				4: begin
					write_reg(CFG_X_OFFSET, 11'($urandom_range(0, 1023)));
					write_reg(CFG_Y_OFFSET, 11'($urandom_range(0, 1023)));
					write_reg(CFG_LINE_PITCH, 11'd2047);
				end
				default: begin
					write_reg(CFG_X_OFFSET, 11'($urandom_range(0, 2047)));
					write_reg(CFG_Y_OFFSET, 11'($urandom_range(0, 2047)));
					write_reg(CFG_LINE_PITCH, 11'($urandom_range(0, 2047)));
				end
			endcase
			idle_level = ph % 3;
			// receiver holds off while the sender keeps going
			if (ph == 1)
				hold_requests++;
			gen_random(55);
			// sender pauses until every result is back
			if (ph == 3)
				settle();
			gen_random(55);
			if (ph % 2 == 0)
				push_key_frame(VIDEO_ROWS, 1'b1);
			settle();
		end

		if (mismatches == 0 && decoded_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
